### sv/bdbs_pkg.sv
// ----------------------------------------------------------------------------
// bdbs_pkg
// Shared types and constants of the bus decoder with bank switch.
// ----------------------------------------------------------------------------
`default_nettype none

package bdbs_pkg;

    localparam int ROM_BANK_BITS = 7;
    localparam int RAM_BANK_MAX  = 3;
    localparam int RAM_BANK_W    = 2;
    localparam int ADDR_W        = 16;
    localparam int DATA_W        = 8;
    localparam int REGION_W      = 4;
    localparam int OFFSET_W      = 21;

    // region codes
    localparam logic [REGION_W-1:0] REGION_BOOT = 4'd0;
    localparam logic [REGION_W-1:0] REGION_CROM = 4'd1;
    localparam logic [REGION_W-1:0] REGION_CRAM = 4'd2;
    localparam logic [REGION_W-1:0] REGION_VRAM = 4'd3;
    localparam logic [REGION_W-1:0] REGION_WRAM = 4'd4;
    localparam logic [REGION_W-1:0] REGION_OAM  = 4'd5;
    localparam logic [REGION_W-1:0] REGION_IO   = 4'd6;
    localparam logic [REGION_W-1:0] REGION_HRAM = 4'd7;
    localparam logic [REGION_W-1:0] REGION_IE   = 4'd8;
    localparam logic [REGION_W-1:0] REGION_JOY  = 4'd9;
    localparam logic [REGION_W-1:0] REGION_NONE = 4'd10;

    // configuration register indexes
    localparam logic CFG_MBC_PRESENT     = 1'b0;
    localparam logic CFG_EXT_RAM_PRESENT = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_data;
    } access_t;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [OFFSET_W-1:0] offset;
        logic                store_enable;
        logic                divider_reset;
        logic                line_reset;
        logic                dma_request;
        logic                io_unhandled;
    } result_t;

    typedef struct packed {
        logic [ROM_BANK_BITS-1:0] rom_bank;
        logic [RAM_BANK_W-1:0]    ram_bank;
        logic                     banking_mode;
        logic                     boot_disabled;
    } bank_state_t;

    typedef struct packed {
        logic mbc_present;
        logic ext_ram_present;
    } cfg_t;

endpackage

`default_nettype wire

### sv/bdbs_decode.sv
// ----------------------------------------------------------------------------
// bdbs_decode
// Address decode of one bus word and next value of the bank controller state.
// ----------------------------------------------------------------------------
`default_nettype none

module bdbs_decode (
    input  wire bdbs_pkg::access_t     acc,
    input  wire bdbs_pkg::bank_state_t state,
    input  wire bdbs_pkg::cfg_t        cfg,
    output bdbs_pkg::result_t          res,
    output bdbs_pkg::bank_state_t      state_next
);

    // io registers that are plain storage
    function automatic logic plain_io(input logic [6:0] lo);
        logic hit;
        hit = (lo == 7'h01) || (lo == 7'h02) || (lo == 7'h06) || (lo == 7'h07) ||
              (lo == 7'h0F) || (lo >= 7'h10 && lo <= 7'h14) ||
              (lo >= 7'h16 && lo <= 7'h1E) || (lo >= 7'h20 && lo <= 7'h26) ||
              (lo >= 7'h30 && lo <= 7'h4B) || (lo == 7'h50) || (lo == 7'h7F);
        return hit;
    endfunction

    logic [15:0]                       a;
    logic [7:0]                        d;
    logic                              wr;
    logic [6:0]                        lo;
    logic [4:0]                        low_bank;
    logic [bdbs_pkg::ROM_BANK_BITS-1:0] low_mask;

    assign a        = acc.bus_address;
    assign d        = acc.write_data;
    assign wr       = acc.action;
    assign lo       = a[6:0];
    assign low_bank = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
    assign low_mask = bdbs_pkg::ROM_BANK_BITS'(5'h1F);

    always_comb
    begin
        res        = '0;
        res.region = bdbs_pkg::REGION_NONE;
        state_next = state;

        priority if (a <= 16'h00FF && !state.boot_disabled)
        begin
            res.region = bdbs_pkg::REGION_BOOT;
            res.offset = bdbs_pkg::OFFSET_W'(a);
        end
        else if (a <= 16'h7FFF)
        begin
            res.region = bdbs_pkg::REGION_CROM;
            if (a < 16'h4000 || !cfg.mbc_present)
                res.offset = bdbs_pkg::OFFSET_W'(a);
            else
                res.offset = bdbs_pkg::OFFSET_W'({state.rom_bank, a[13:0]});
            // writes into the rom window drive the bank controller
            if (wr)
            begin
                unique case (a[14:13])
                    2'b00: ;
                    2'b01: state_next.rom_bank = (state.rom_bank & ~low_mask) |
                                                 bdbs_pkg::ROM_BANK_BITS'(low_bank);
                    2'b10:
                    begin
                        if (!state.banking_mode)
                            state_next.rom_bank = (state.rom_bank & low_mask) |
                                bdbs_pkg::ROM_BANK_BITS'({d[1:0], 5'd0});
                        else if (d > 8'(bdbs_pkg::RAM_BANK_MAX))
                            state_next.ram_bank = bdbs_pkg::RAM_BANK_W'(bdbs_pkg::RAM_BANK_MAX);
                        else
                            state_next.ram_bank = d[bdbs_pkg::RAM_BANK_W-1:0];
                    end
                    2'b11: state_next.banking_mode = d[0];
                    default: ;
                endcase
            end
        end
        else if (a <= 16'h9FFF)
        begin
            res.region       = bdbs_pkg::REGION_VRAM;
            res.offset       = bdbs_pkg::OFFSET_W'(a[12:0]);
            res.store_enable = wr;
        end
        else if (a <= 16'hBFFF)
        begin
            if (cfg.ext_ram_present)
            begin
                res.region       = bdbs_pkg::REGION_CRAM;
                res.store_enable = wr;
                if (cfg.mbc_present)
                    res.offset = bdbs_pkg::OFFSET_W'({state.ram_bank, a[12:0]});
                else
                    res.offset = bdbs_pkg::OFFSET_W'(a[12:0]);
            end
        end
        else if (a <= 16'hDFFF)
        begin
            res.region       = bdbs_pkg::REGION_WRAM;
            res.offset       = bdbs_pkg::OFFSET_W'(a[12:0]);
            res.store_enable = wr;
        end
        else if (a <= 16'hFDFF)
        begin
            // echo area, left unmapped
        end
        else if (a <= 16'hFE9F)
        begin
            res.region       = bdbs_pkg::REGION_OAM;
            res.offset       = bdbs_pkg::OFFSET_W'(a[7:0]);
            res.store_enable = wr;
        end
        else if (a <= 16'hFEFF)
        begin
            // unused hole
        end
        else if (a <= 16'hFF7F)
        begin
            priority if (lo == 7'h00)
            begin
                if (wr)
                begin
                    res.region       = bdbs_pkg::REGION_IO;
                    res.store_enable = 1'b1;
                end
                else
                    res.region = bdbs_pkg::REGION_JOY;
            end
            else if (lo == 7'h04 || lo == 7'h44)
            begin
                res.region        = bdbs_pkg::REGION_IO;
                res.offset        = bdbs_pkg::OFFSET_W'(lo);
                res.divider_reset = wr && (lo == 7'h04);
                res.line_reset    = wr && (lo == 7'h44);
            end
            else if (lo == 7'h46)
            begin
                if (wr)
                begin
                    res.region       = bdbs_pkg::REGION_IO;
                    res.offset       = bdbs_pkg::OFFSET_W'(lo);
                    res.store_enable = 1'b1;
                    res.dma_request  = 1'b1;
                end
            end
            else if (plain_io(lo))
            begin
                res.region       = bdbs_pkg::REGION_IO;
                res.offset       = bdbs_pkg::OFFSET_W'(lo);
                res.store_enable = wr;
                if (wr && lo == 7'h50)
                    state_next.boot_disabled = (d != 8'd0);
            end
            else
                res.io_unhandled = 1'b1;
        end
        else if (a <= 16'hFFFE)
        begin
            res.region       = bdbs_pkg::REGION_HRAM;
            res.offset       = bdbs_pkg::OFFSET_W'(a[6:0]);
            res.store_enable = wr;
        end
        else
        begin
            res.region       = bdbs_pkg::REGION_IE;
            res.store_enable = wr;
        end
    end

endmodule

`default_nettype wire

### sv/bus_decoder_with_bank_switch_unit.sv
// ----------------------------------------------------------------------------
// bus_decoder_with_bank_switch_unit
// Memory map decode with a bank controller for cartridge rom and ram.
// ----------------------------------------------------------------------------
// One bus access enters on the input channel (in_valid/in_stall with action,
// bus_address, write_data) and one decoded word leaves on the output channel
// (out_valid/out_stall with region, offset, store_enable and the side-effect
// flags). A word is taken at a clock edge with valid high and stall low.
// The access is captured in an input register, decoded by one level of
// compare and select logic against the bank state, and lands in a result
// register: out_valid rises when the access moves into the result register, and
// one access per cycle is sustained while the receiver does not stall. Bank
// state updates in the same cycle the access moves into the result register,
// so a following access already sees the new bank.
// While the receiver stalls, the result register holds; the input register
// still fills and in_stall rises only once both registers hold words.
// Config writes (cfg_wr_en, cfg_index, cfg_data) take effect at once and are
// meant for idle periods. Reset clears both channels, both config registers,
// selects rom bank 1, ram bank 0, rom banking mode and the boot overlay.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_decoder_with_bank_switch_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_wr_en,
    input  wire                                cfg_index,
    input  wire                                cfg_data,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire                                action,
    input  wire  [bdbs_pkg::ADDR_W-1:0]        bus_address,
    input  wire  [bdbs_pkg::DATA_W-1:0]        write_data,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [bdbs_pkg::REGION_W-1:0]      region,
    output logic [bdbs_pkg::OFFSET_W-1:0]      offset,
    output logic                               store_enable,
    output logic                               divider_reset,
    output logic                               line_reset,
    output logic                               dma_request,
    output logic                               io_unhandled
);

    bdbs_pkg::cfg_t        cfg_reg;
    bdbs_pkg::bank_state_t state_reg;
    bdbs_pkg::bank_state_t state_next;
    bdbs_pkg::access_t     acc_reg;
    bdbs_pkg::result_t     res_next;
    bdbs_pkg::result_t     res_reg;
    logic                  acc_valid_reg;
    logic                  res_valid_reg;
    logic                  advance;
    logic                  in_take;

    // result register frees up when empty or being taken
    assign advance  = !res_valid_reg || !out_stall;
    assign in_stall = acc_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    bdbs_decode u_decode (
        .acc        (acc_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .res        (res_next),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                 <= '0;
            state_reg.rom_bank      <= bdbs_pkg::ROM_BANK_BITS'(1);
            state_reg.ram_bank      <= '0;
            state_reg.banking_mode  <= 1'b0;
            state_reg.boot_disabled <= 1'b0;
            acc_valid_reg           <= 1'b0;
            res_valid_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    bdbs_pkg::CFG_MBC_PRESENT:     cfg_reg.mbc_present     <= cfg_data;
                    bdbs_pkg::CFG_EXT_RAM_PRESENT: cfg_reg.ext_ram_present <= cfg_data;
                    default: ;
                endcase
            end
            if (advance)
            begin
                res_valid_reg <= acc_valid_reg;
                if (acc_valid_reg)
                    state_reg <= state_next;
            end
            if (in_take)
                acc_valid_reg <= 1'b1;
            else if (advance)
                acc_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            acc_reg.action      <= action;
            acc_reg.bus_address <= bus_address;
            acc_reg.write_data  <= write_data;
        end
        if (advance && acc_valid_reg)
            res_reg <= res_next;
    end

    assign out_valid     = res_valid_reg;
    assign region        = res_reg.region;
    assign offset        = res_reg.offset;
    assign store_enable  = res_reg.store_enable;
    assign divider_reset = res_reg.divider_reset;
    assign line_reset    = res_reg.line_reset;
    assign dma_request   = res_reg.dma_request;
    assign io_unhandled  = res_reg.io_unhandled;

endmodule

`default_nettype wire
